/* hw/rtl/pfe_pkg.sv */
// Shared constants, types and helper functions of the Playfair digraph encryptor.
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned FuncW = 2;
  localparam int unsigned NumCodes = 26;
  localparam int unsigned SqSize = 25;
  localparam int unsigned SqSide = 5;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 16;

  localparam logic [LetterW-1:0] LetterX = LetterW'(23);
  localparam logic [LetterW-1:0] LetterQ = LetterW'(16);
  localparam logic [LetterW-1:0] FillLast = LetterW'(SqSize - 1);

  localparam logic [FuncW-1:0] FuncKey = 2'd0;
  localparam logic [FuncW-1:0] FuncKeyDone = 2'd1;
  localparam logic [FuncW-1:0] FuncText = 2'd2;
  localparam logic [FuncW-1:0] FuncTextEnd = 2'd3;

  localparam logic StatusOk = 1'b0;
  localparam logic StatusAbsent = 1'b1;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [2:0] coord_t;

  typedef struct packed {
    logic place;
    logic place_src_fill;
    logic fill_clr;
    logic fill_inc;
    logic pend_set;
    logic pend_clr;
    logic load_pair;
    logic pair_b_x;
    logic err_set;
    logic rd_pos;
    logic rd_pos_b;
    logic cap_pa;
    logic rd_sq;
    logic sq_sel_idx2;
    logic cap_c1;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic code_valid;
    logic code_used;
    logic place_ok_in;
    logic place_ok_fill;
    logic fill_last;
    logic pend_valid;
    logic pend_eq;
    logic pair_used;
    logic out_free;
  } stat_t;

  // The fill alphabet is A..Z without Q.
  function automatic letter_t fill_code(input letter_t idx);
    fill_code = (idx < LetterQ) ? idx : idx + LetterW'(1);
  endfunction

  function automatic coord_t pos_row(input letter_t pos);
    if (pos < LetterW'(SqSide)) begin
      pos_row = 3'd0;
    end else if (pos < LetterW'(2 * SqSide)) begin
      pos_row = 3'd1;
    end else if (pos < LetterW'(3 * SqSide)) begin
      pos_row = 3'd2;
    end else if (pos < LetterW'(4 * SqSide)) begin
      pos_row = 3'd3;
    end else begin
      pos_row = 3'd4;
    end
  endfunction

  function automatic coord_t pos_col(input letter_t pos);
    letter_t base;
    base = (LetterW'(pos_row(pos)) << 2) + LetterW'(pos_row(pos));
    pos_col = 3'(pos - base);
  endfunction

  function automatic coord_t wrap_inc(input coord_t x);
    wrap_inc = (x == 3'(SqSide - 1)) ? 3'd0 : x + 3'd1;
  endfunction

  function automatic letter_t cell_idx(input coord_t row, input coord_t col);
    cell_idx = (LetterW'(row) << 2) + LetterW'(row) + LetterW'(col);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pfe_datapath.sv */
// Datapath of the Playfair encryptor: square and position memories, pair registers, output stage.
`timescale 1ns / 1ps
`default_nettype none

module pfe_datapath (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire pfe_pkg::letter_t       in_letter_i,
  input  wire pfe_pkg::cmd_t          cmd_i,
  output pfe_pkg::stat_t              stat_o,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output pfe_pkg::letter_t            out_first_o,
  output pfe_pkg::letter_t            out_second_o,
  output logic                        out_status_o
);

  logic [pfe_pkg::LetterW-1:0] sq_mem_q [pfe_pkg::SqSize];
  logic [pfe_pkg::LetterW-1:0] pos_mem_q [pfe_pkg::NumCodes];
  logic [pfe_pkg::NumCodes-1:0] used_q;
  pfe_pkg::letter_t count_q;
  pfe_pkg::letter_t fill_idx_q;
  logic pend_valid_q;
  pfe_pkg::letter_t pend_letter_q;
  logic err_q;
  logic out_valid_q;

  pfe_pkg::letter_t a_q, b_q, pa_q, idx2_q, c1_q;
  pfe_pkg::letter_t pos_rdata_q, sq_rdata_q;
  pfe_pkg::letter_t first_q, second_q;
  logic status_q;

  pfe_pkg::letter_t fill_letter, place_code, idx1, idx2, pb;
  pfe_pkg::coord_t r1, c1, r2, c2;
  logic code_valid, not_full;

  assign code_valid = in_letter_i < pfe_pkg::LetterW'(pfe_pkg::NumCodes);
  assign not_full = count_q < pfe_pkg::LetterW'(pfe_pkg::SqSize);
  assign fill_letter = pfe_pkg::fill_code(fill_idx_q);
  assign place_code = cmd_i.place_src_fill ? fill_letter : in_letter_i;

  always_comb begin
    stat_o = '0;
    stat_o.code_valid = code_valid;
    stat_o.code_used = code_valid && used_q[in_letter_i];
    stat_o.place_ok_in = code_valid && !used_q[in_letter_i] && not_full;
    stat_o.place_ok_fill = !used_q[fill_letter] && not_full;
    stat_o.fill_last = fill_idx_q == pfe_pkg::FillLast;
    stat_o.pend_valid = pend_valid_q;
    stat_o.pend_eq = pend_letter_q == in_letter_i;
    stat_o.pair_used = used_q[a_q] && used_q[b_q];
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  // Cipher cell selection from the two positions.
  assign pb = pos_rdata_q;
  assign r1 = pfe_pkg::pos_row(pa_q);
  assign c1 = pfe_pkg::pos_col(pa_q);
  assign r2 = pfe_pkg::pos_row(pb);
  assign c2 = pfe_pkg::pos_col(pb);

  always_comb begin
    if (r1 == r2) begin
      idx1 = pfe_pkg::cell_idx(r1, pfe_pkg::wrap_inc(c1));
      idx2 = pfe_pkg::cell_idx(r2, pfe_pkg::wrap_inc(c2));
    end else if (c1 == c2) begin
      idx1 = pfe_pkg::cell_idx(pfe_pkg::wrap_inc(r1), c1);
      idx2 = pfe_pkg::cell_idx(pfe_pkg::wrap_inc(r2), c2);
    end else begin
      idx1 = pfe_pkg::cell_idx(r1, c2);
      idx2 = pfe_pkg::cell_idx(r2, c1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.place) begin
      sq_mem_q[count_q] <= place_code;
      pos_mem_q[place_code] <= count_q;
    end
    if (cmd_i.rd_pos) begin
      pos_rdata_q <= pos_mem_q[cmd_i.rd_pos_b ? b_q : a_q];
    end
    if (cmd_i.rd_sq) begin
      sq_rdata_q <= sq_mem_q[cmd_i.sq_sel_idx2 ? idx2_q : idx1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pair) begin
      a_q <= pend_letter_q;
      b_q <= cmd_i.pair_b_x ? pfe_pkg::LetterX : in_letter_i;
    end
    if (cmd_i.cap_pa) begin
      pa_q <= pos_rdata_q;
    end
    if (cmd_i.rd_sq && !cmd_i.sq_sel_idx2) begin
      idx2_q <= idx2;
    end
    if (cmd_i.cap_c1) begin
      c1_q <= sq_rdata_q;
    end
    if (cmd_i.out_load) begin
      first_q <= err_q ? '0 : c1_q;
      second_q <= err_q ? '0 : sq_rdata_q;
      status_q <= err_q ? pfe_pkg::StatusAbsent : pfe_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      count_q <= '0;
      fill_idx_q <= '0;
      pend_valid_q <= 1'b0;
      pend_letter_q <= '0;
      err_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.place) begin
        used_q[place_code] <= 1'b1;
        count_q <= count_q + pfe_pkg::LetterW'(1);
      end
      if (cmd_i.fill_clr) begin
        fill_idx_q <= '0;
      end else if (cmd_i.fill_inc) begin
        fill_idx_q <= fill_idx_q + pfe_pkg::LetterW'(1);
      end
      if (cmd_i.pend_set) begin
        pend_valid_q <= 1'b1;
        pend_letter_q <= in_letter_i;
      end else if (cmd_i.pend_clr) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.err_set) begin
        err_q <= 1'b1;
      end else if (cmd_i.load_pair) begin
        err_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_first_o = first_q;
  assign out_second_o = second_q;
  assign out_status_o = status_q;

endmodule

`default_nettype wire

/* hw/rtl/pfe_ctrl.sv */
// Controller state machine of the Playfair encryptor.
`timescale 1ns / 1ps
`default_nettype none

module pfe_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [pfe_pkg::FuncW-1:0] in_func_i,
  input  wire pfe_pkg::stat_t           stat_i,
  output pfe_pkg::cmd_t                 cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StFill = 3'd1;
  localparam logic [2:0] StPosA = 3'd2;
  localparam logic [2:0] StPosB = 3'd3;
  localparam logic [2:0] StCellA = 3'd4;
  localparam logic [2:0] StCellB = 3'd5;
  localparam logic [2:0] StEmit = 3'd6;

  logic [2:0] state_q, state_d;
  logic accept;

  assign in_ready_o = state_q == StIdle;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (in_func_i)
            pfe_pkg::FuncKey: begin
              cmd_o.place = stat_i.place_ok_in;
            end
            pfe_pkg::FuncKeyDone: begin
              cmd_o.fill_clr = 1'b1;
              state_d = StFill;
            end
            pfe_pkg::FuncTextEnd: begin
              if (stat_i.pend_valid) begin
                cmd_o.pend_clr = 1'b1;
                cmd_o.load_pair = 1'b1;
                cmd_o.pair_b_x = 1'b1;
                state_d = StPosA;
              end
            end
            pfe_pkg::FuncText: begin
              if (stat_i.code_valid) begin
                if (!stat_i.code_used) begin
                  cmd_o.err_set = 1'b1;
                  state_d = StEmit;
                end else if (!stat_i.pend_valid) begin
                  cmd_o.pend_set = 1'b1;
                end else begin
                  cmd_o.load_pair = 1'b1;
                  cmd_o.pair_b_x = stat_i.pend_eq;
                  cmd_o.pend_clr = !stat_i.pend_eq;
                  state_d = StPosA;
                end
              end
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StFill: begin
        cmd_o.place = stat_i.place_ok_fill;
        cmd_o.place_src_fill = 1'b1;
        cmd_o.fill_inc = 1'b1;
        if (stat_i.fill_last) begin
          state_d = StIdle;
        end
      end
      StPosA: begin
        if (!stat_i.pair_used) begin
          cmd_o.err_set = 1'b1;
          state_d = StEmit;
        end else begin
          cmd_o.rd_pos = 1'b1;
          state_d = StPosB;
        end
      end
      StPosB: begin
        cmd_o.cap_pa = 1'b1;
        cmd_o.rd_pos = 1'b1;
        cmd_o.rd_pos_b = 1'b1;
        state_d = StCellA;
      end
      StCellA: begin
        cmd_o.rd_sq = 1'b1;
        state_d = StCellB;
      end
      StCellB: begin
        cmd_o.cap_c1 = 1'b1;
        cmd_o.rd_sq = 1'b1;
        cmd_o.sq_sel_idx2 = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/playfair_digraph_encryptor_core.sv */
// Top level of the Playfair digraph encryptor: stream ports, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Encrypts text with a 5x5 Playfair square over A..Z without Q. Key letters
// (func 0) and key done (func 1) build the square, key done placing one fill
// letter per cycle after the accepting one. Text letters (func 2) are paired,
// with X inserted between doubled letters, and text end (func 3) pads a lone
// letter with X. A beat that completes a pair passes the states PosA, PosB,
// CellA, CellB and Emit up to the output register, as the position memory and
// the square memory each have a single read port and are each read twice in
// turn; when a letter of the pair, such as the pad X, is missing from the
// square, PosA goes straight to Emit. A text letter absent from the square
// goes straight to Emit and yields a beat with status 1 and zero letters. The
// next input beat is taken while a result waits at the output, so a stalled
// output holds back only a further result and the input beats behind it.
module playfair_digraph_encryptor_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [pfe_pkg::InDataW-1:0]    s_axis_tdata,  // letter[4:0], zeros
  input  wire logic [pfe_pkg::FuncW-1:0]      s_axis_tuser,  // func[1:0]
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [pfe_pkg::OutDataW-1:0]        m_axis_tdata,  // first[4:0], second[9:5], zeros
  output logic                                m_axis_tuser   // status[0]
);

  pfe_pkg::cmd_t cmd;
  pfe_pkg::stat_t stat;
  pfe_pkg::letter_t first, second;

  pfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (s_axis_tuser),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfe_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_letter_i  (s_axis_tdata[pfe_pkg::LetterW-1:0]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_first_o  (first),
    .out_second_o (second),
    .out_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = {(pfe_pkg::OutDataW - 2 * pfe_pkg::LetterW)'(0), second, first};

endmodule

`default_nettype wire
